// File: hw/rtl/psu_pkg.sv
// Shared types and constants for the PNG scanline unfilter block.
package psu_pkg;

  localparam int ROW_W     = 14;
  localparam int PIX_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [ROW_W-1:0] ROW_BYTES_RST = 14'd1024;
  localparam logic [PIX_W-1:0] PIX_BYTES_RST = 4'd4;

  // Output queue: deep enough for the compute stage plus two waiting words.
  localparam int OQ_DEPTH = 3;
  localparam int OQ_PTR_W = 2;
  localparam int OQ_CNT_W = 2;
  localparam logic [OQ_CNT_W:0] OQ_ACCEPT_MAX = 3'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_BYTES = 2'd0,
    REG_PIX_BYTES = 2'd1
  } psu_reg_e;

  localparam logic [7:0] FILT_NONE  = 8'd0;
  localparam logic [7:0] FILT_SUB   = 8'd1;
  localparam logic [7:0] FILT_UP    = 8'd2;
  localparam logic [7:0] FILT_AVG   = 8'd3;
  localparam logic [7:0] FILT_PAETH = 8'd4;

  typedef struct packed {
    logic [7:0] filtered_byte;
    logic       image_start;
  } in_word_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       row_last;
  } out_word_t;

  // Data byte handed from the row sequencer to the reconstruction stage.
  typedef struct packed {
    logic       valid;
    logic       last;
    logic       first_row;
    logic [7:0] row_filter;
    logic [7:0] data;
  } psu_issue_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } psu_result_t;

endpackage

// File: hw/rtl/psu_front.sv
// Row sequencer: filter byte capture, column count and prior-row read issue.
module psu_front import psu_pkg::*; #(
  parameter int COL_W = 13,
  parameter int LEN_W = 14
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  in_word_t         in_data,
  input  logic [LEN_W-1:0] row_len,
  output psu_issue_t       issue,
  output logic [COL_W-1:0] issue_col,
  output logic             hist_clr
);

  logic [COL_W-1:0] column_r, column_nxt;
  logic [7:0]       row_filter_r, row_filter_nxt;
  logic             first_row_r, first_row_nxt;
  logic             await_r, await_nxt;
  logic [LEN_W-1:0] col_inc;
  logic             is_filter;
  logic             row_end;

  always_comb begin
    column_nxt     = column_r;
    row_filter_nxt = row_filter_r;
    first_row_nxt  = first_row_r;
    await_nxt      = await_r;
    col_inc        = LEN_W'(column_r) + LEN_W'(1);
    row_end        = (col_inc >= row_len);
    is_filter      = await_r || in_data.image_start;
    hist_clr       = accept && is_filter;

    issue.valid      = accept && !is_filter;
    issue.last       = row_end;
    issue.first_row  = first_row_r;
    issue.row_filter = row_filter_r;
    issue.data       = in_data.filtered_byte;
    issue_col        = column_r;

    if (accept) begin
      if (is_filter) begin
        if (in_data.image_start) first_row_nxt = 1'b1;
        row_filter_nxt = in_data.filtered_byte;
        column_nxt     = '0;
        await_nxt      = 1'b0;
      end else if (row_end) begin
        column_nxt    = '0;
        first_row_nxt = 1'b0;
        await_nxt     = 1'b1;
      end else begin
        column_nxt = COL_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r     <= '0;
      row_filter_r <= FILT_NONE;
      first_row_r  <= 1'b1;
      await_r      <= 1'b1;
    end else begin
      column_r     <= column_nxt;
      row_filter_r <= row_filter_nxt;
      first_row_r  <= first_row_nxt;
      await_r      <= await_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_last_awaits_filter: assert property (@(posedge clk) disable iff (!rst_n)
    issue.valid && issue.last |=> await_r && column_r == '0)
    else $error("row end did not return to filter byte");

  a_clr_not_data: assert property (@(posedge clk) disable iff (!rst_n)
    hist_clr |-> !issue.valid)
    else $error("filter byte issued as data");
`endif

endmodule

// File: hw/rtl/psu_recon.sv
// Reconstruction stage: prior-row memory, pixel histories and filter predictor.
module psu_recon import psu_pkg::*; #(
  parameter int MAX_ROW_BYTES   = 8192,
  parameter int MAX_PIXEL_BYTES = 8,
  parameter int COL_W           = 13,
  parameter int PIX_IW          = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  psu_issue_t        issue,
  input  logic [COL_W-1:0]  issue_col,
  input  logic              hist_clr,
  input  logic [PIX_IW-1:0] pix_idx,
  output psu_result_t       result
);

  logic [7:0] prior_mem [MAX_ROW_BYTES];
  logic [7:0] rd_data_r;

  psu_issue_t       s1_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_valid_r;

  logic [7:0] left_r  [MAX_PIXEL_BYTES];
  logic [7:0] above_r [MAX_PIXEL_BYTES];

  logic [7:0]        nb_a, nb_b, nb_c, pred, recon;
  logic [8:0]        sum_ab;
  logic signed [9:0] d_bc, d_ac, d_sum;
  logic [8:0]        dist_a, dist_b, dist_c;

  function automatic logic [8:0] abs10(input logic signed [9:0] v);
    logic signed [9:0] m;
    m = (v < 0) ? -v : v;
    return m[8:0];
  endfunction

  always_comb begin
    nb_a   = left_r[pix_idx];
    nb_c   = above_r[pix_idx];
    nb_b   = s1_r.first_row ? 8'd0 : rd_data_r;
    sum_ab = {1'b0, nb_a} + {1'b0, nb_b};
    d_bc   = $signed({2'b00, nb_b}) - $signed({2'b00, nb_c});
    d_ac   = $signed({2'b00, nb_a}) - $signed({2'b00, nb_c});
    d_sum  = d_bc + d_ac;
    dist_a = abs10(d_bc);
    dist_b = abs10(d_ac);
    dist_c = abs10(d_sum);
    unique case (s1_r.row_filter)
      FILT_SUB:   pred = nb_a;
      FILT_UP:    pred = nb_b;
      FILT_AVG:   pred = sum_ab[8:1];
      FILT_PAETH: begin
        if (dist_a <= dist_b && dist_a <= dist_c) pred = nb_a;
        else if (dist_b <= dist_c)               pred = nb_b;
        else                                     pred = nb_c;
      end
      default:    pred = 8'd0;
    endcase
    recon = s1_r.data + pred;

    result.valid           = s1_valid_r;
    result.word.pixel_byte = recon;
    result.word.row_last   = s1_r.last;
  end

  // Prior row: read the above byte as the word enters, write back the result.
  always_ff @(posedge clk) begin
    if (issue.valid) rd_data_r <= prior_mem[issue_col];
    if (s1_valid_r) prior_mem[s1_col_r] <= recon;
  end

  always_ff @(posedge clk) begin
    if (issue.valid) begin
      s1_r     <= issue;
      s1_col_r <= issue_col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= issue.valid;
  end

  // Clear on a filter byte wins over a push from the previous row's tail.
  always_ff @(posedge clk) begin
    if (!rst_n || hist_clr) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_r[i]  <= 8'd0;
        above_r[i] <= 8'd0;
      end
    end else if (s1_valid_r) begin
      for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
        left_r[i]  <= left_r[i-1];
        above_r[i] <= above_r[i-1];
      end
      left_r[0]  <= recon;
      above_r[0] <= nb_b;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    issue.valid && s1_valid_r |-> issue_col != s1_col_r)
    else $error("prior row read and write hit the same entry");

  a_hist_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    $past(hist_clr) |-> left_r[0] == 8'd0 && above_r[0] == 8'd0)
    else $error("history not cleared after filter byte");
`endif

endmodule

// File: hw/rtl/psu_outq.sv
// Output queue: holds reconstructed words until the receiver takes them.
module psu_outq import psu_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  psu_result_t         result,
  output logic                out_valid,
  input  logic                out_stall,
  output out_word_t           out_data,
  output logic [OQ_CNT_W-1:0] count
);

  out_word_t           q_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [OQ_CNT_W-1:0] count_r, count_nxt;
  logic                push, pop;

  function automatic logic [OQ_PTR_W-1:0] wrap_inc(input logic [OQ_PTR_W-1:0] p);
    return (p == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : p + OQ_PTR_W'(1);
  endfunction

  always_comb begin
    push      = result.valid;
    out_valid = (count_r != '0);
    pop       = out_valid && !out_stall;
    out_data  = q_r[head_r];
    count     = count_r;
    head_nxt  = pop  ? wrap_inc(head_r) : head_r;
    tail_nxt  = push ? wrap_inc(tail_r) : tail_r;
    count_nxt = count_r + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) q_r[tail_r] <= result.word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> count_r != OQ_CNT_W'(OQ_DEPTH))
    else $error("output queue overflow");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + OQ_CNT_W'(1))
    else $error("output queue count lost a word");
`endif

endmodule

// File: hw/rtl/png_scanline_unfilter.sv
// Top level of the PNG scanline unfilter (filter method 0 reconstruction).
//
// Input: one inflated stream byte per word on in_valid/in_stall. The first
// byte of each row is its filter type and yields no output; image_start on a
// filter byte makes the above row read as zero. Output: one reconstructed
// byte per data byte on out_valid/out_stall, row_last on the final byte.
// Configuration: cfg_valid/cfg_ready with cfg_index 0 for row_bytes and 1
// for bytes_per_pixel; write only while the block is idle.
// Throughput: one byte per cycle while in_stall is low. A data byte accepted
// is registered in the compute stage, then written into the output queue,
// which offers it on out_data; the above byte comes from a registered read
// of the prior-row memory and the result is written back to the same entry
// in the cycle after the read.
// Stall: a three-word output queue absorbs the compute stage; in_stall is
// raised from registered state when the queue plus the word in flight leave
// no room, so output stalls back up to the input after two waiting words.
// Reset: rows restart with a filter byte, the first row reads zero above,
// row_bytes returns to 1024 and bytes_per_pixel to 4. The prior-row memory
// is not cleared; its contents are undefined until a row writes them.
module png_scanline_unfilter import psu_pkg::*; #(
  parameter int MAX_ROW_BYTES   = 8192,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W  = $clog2(MAX_ROW_BYTES);
  localparam int LEN_W  = $clog2(MAX_ROW_BYTES + 1);
  localparam int CMP_W  = (LEN_W > ROW_W) ? LEN_W : ROW_W;
  localparam int PIX_IW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  logic [ROW_W-1:0]    row_bytes_r;
  logic [PIX_W-1:0]    pix_bytes_r;
  logic [CMP_W-1:0]    row_wide;
  logic [LEN_W-1:0]    row_len;
  logic [PIX_IW-1:0]   pix_idx;
  logic                accept;
  logic [OQ_CNT_W:0]   occupancy;
  logic [OQ_CNT_W-1:0] q_count;

  psu_issue_t       issue;
  logic [COL_W-1:0] issue_col;
  logic             hist_clr;
  psu_result_t      result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r <= ROW_BYTES_RST;
      pix_bytes_r <= PIX_BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW_BYTES: row_bytes_r <= cfg_data[ROW_W-1:0];
        REG_PIX_BYTES: pix_bytes_r <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp row length to 1..MAX_ROW_BYTES and pixel size to 1..MAX_PIXEL_BYTES.
  always_comb begin
    row_wide = CMP_W'(row_bytes_r);
    if (row_wide == '0)                           row_len = LEN_W'(1);
    else if (row_wide > CMP_W'(MAX_ROW_BYTES))    row_len = LEN_W'(MAX_ROW_BYTES);
    else                                          row_len = LEN_W'(row_wide);

    if (pix_bytes_r == '0)                        pix_idx = '0;
    else if (pix_bytes_r > PIX_W'(MAX_PIXEL_BYTES)) pix_idx = PIX_IW'(MAX_PIXEL_BYTES - 1);
    else                                          pix_idx = PIX_IW'(pix_bytes_r - PIX_W'(1));
  end

  assign occupancy = {1'b0, q_count} + {{OQ_CNT_W{1'b0}}, result.valid};
  assign in_stall  = (occupancy > OQ_ACCEPT_MAX);
  assign accept    = in_valid && !in_stall;

  psu_front #(
    .COL_W (COL_W),
    .LEN_W (LEN_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .row_len   (row_len),
    .issue     (issue),
    .issue_col (issue_col),
    .hist_clr  (hist_clr)
  );

  psu_recon #(
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
    .COL_W           (COL_W),
    .PIX_IW          (PIX_IW)
  ) u_recon (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .issue_col (issue_col),
    .hist_clr  (hist_clr),
    .pix_idx   (pix_idx),
    .result    (result)
  );

  psu_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .result    (result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .count     (q_count)
  );

`ifndef NO_ASSERTIONS
  a_room_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> q_count != OQ_CNT_W'(OQ_DEPTH) || !result.valid || (out_valid && !out_stall))
    else $error("word accepted without queue room");
`endif

endmodule
